// File: rtl/vad_pkg.sv
`default_nettype none

package vad_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int HEAD_WIDTH      = ANGLE_FRAC_BITS + 9;

   localparam int Z_FRAC    = 20;
   localparam int PRE_SHIFT = 30 - SAMPLE_WIDTH;
   localparam int STAGES    = 24;
   localparam int PATH_W    = 33;
   localparam int Z_W       = 29;

   localparam int ROUND_STG = STAGES + 1;
   localparam int OUT_STG   = STAGES + 2;
   localparam int NSTG      = STAGES + 3;

   localparam int Z_MAX   = 90 << Z_FRAC;
   localparam int Z_HALF  = 1 << (Z_FRAC - 1 - ANGLE_FRAC_BITS);
   localparam int Z_SHIFT = Z_FRAC - ANGLE_FRAC_BITS;

   localparam int UNIT = 1 << ANGLE_FRAC_BITS;
   localparam logic [HEAD_WIDTH-1:0] H90  = HEAD_WIDTH'(90 * UNIT);
   localparam logic [HEAD_WIDTH-1:0] H180 = HEAD_WIDTH'(180 * UNIT);
   localparam logic [HEAD_WIDTH-1:0] H360 = HEAD_WIDTH'(360 * UNIT);

   localparam int ATAN_TAB [STAGES] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
      938658, 469357, 234682, 117342, 58671, 29335,
      14668, 7334, 3667, 1833, 917, 458,
      229, 115, 57, 29, 14, 7
   };

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [HEAD_WIDTH-1:0] heading_type;

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic x_zero;
      logic y_zero;
   } quad_type;

   typedef struct packed {
      logic signed [PATH_W-1:0] x;
      logic signed [PATH_W-1:0] y;
      logic signed [Z_W-1:0]    z;
      quad_type                 quad;
   } cordic_type;

   function automatic cordic_type cordic_step(input cordic_type c, input int stage);
      cordic_type r;
      logic signed [PATH_W-1:0] dx;
      logic signed [PATH_W-1:0] dy;
      logic signed [Z_W-1:0]    za;
      dx = c.y >>> stage;
      dy = c.x >>> stage;
      za = Z_W'(ATAN_TAB[stage]);
      r = c;
      if (!c.y[PATH_W-1]) begin
         r.x = c.x + dx;
         r.y = c.y - dy;
         r.z = c.z + za;
      end else begin
         r.x = c.x - dx;
         r.y = c.y + dy;
         r.z = c.z - za;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/vad_if.sv
`default_nettype none

interface vad_req_if;
   import vad_pkg::*;
   logic       valid;
   logic       ready;
   sample_type field_x;
   sample_type field_y;
   modport source (output valid, output field_x, output field_y, input ready);
   modport sink (input valid, input field_x, input field_y, output ready);
endinterface

interface vad_rsp_if;
   import vad_pkg::*;
   logic        valid;
   logic        ready;
   heading_type heading;
   modport source (output valid, output heading, input ready);
   modport sink (input valid, input heading, output ready);
endinterface

`default_nettype wire

// File: rtl/vector_angle_degrees.sv
// pipeline: an accepted req beat passes through the cordic stages, the round stage and the output stage to its rsp beat
// throughput: one beat per cycle while rsp is not stalled, set by one cordic iteration per pipeline stage
// stages with no beat in them keep filling while the output waits, so bubbles collapse
// reset: synchronous, active high, clears the valid bits of all stages; data is not reset
`default_nettype none

module vector_angle_degrees (
   input  wire logic clock,
   input  wire logic reset,
   vad_req_if.sink   req_bus,
   vad_rsp_if.source rsp_bus
);
   import vad_pkg::*;

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] adv;

   cordic_type cordic_ff [STAGES+1];
   cordic_type cordic_in [STAGES+1];

   heading_type t_ff;
   heading_type t_in;
   quad_type    quad_t_ff;
   heading_type heading_ff;
   heading_type heading_in;

   logic signed [SAMPLE_WIDTH:0] xe;
   logic signed [SAMPLE_WIDTH:0] ye;
   logic [SAMPLE_WIDTH:0]        ax;
   logic [SAMPLE_WIDTH:0]        ay;
   logic [PATH_W-1:0]            cx;
   logic [PATH_W-1:0]            cy;

   logic signed [Z_W-1:0] zc;
   logic [Z_W-1:0]        zr;

   // stage advance chain
   always_comb begin
      adv[NSTG-1] = !valid_ff[NSTG-1] || rsp_bus.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_bus.ready   = adv[0];
   assign rsp_bus.valid   = valid_ff[OUT_STG];
   assign rsp_bus.heading = heading_ff;

   // magnitudes and quadrant
   always_comb begin
      xe = (SAMPLE_WIDTH + 1)'(req_bus.field_x);
      ye = (SAMPLE_WIDTH + 1)'(req_bus.field_y);
      ax = xe[SAMPLE_WIDTH] ? $unsigned(-xe) : $unsigned(xe);
      ay = ye[SAMPLE_WIDTH] ? $unsigned(-ye) : $unsigned(ye);
      cx = PATH_W'(ax) << PRE_SHIFT;
      cy = PATH_W'(ay) << PRE_SHIFT;
      cordic_in[0].x           = $signed(cx);
      cordic_in[0].y           = $signed(cy);
      cordic_in[0].z           = '0;
      cordic_in[0].quad.x_neg  = xe[SAMPLE_WIDTH];
      cordic_in[0].quad.y_neg  = ye[SAMPLE_WIDTH];
      cordic_in[0].quad.x_zero = (ax == '0);
      cordic_in[0].quad.y_zero = (ay == '0);
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_cordic
      assign cordic_in[i+1] = cordic_step(cordic_ff[i], i);
   end

   // clamp and round the first-quadrant angle
   always_comb begin
      if (cordic_ff[STAGES].z[Z_W-1]) begin
         zc = '0;
      end else if (cordic_ff[STAGES].z > $signed(Z_W'(Z_MAX))) begin
         zc = $signed(Z_W'(Z_MAX));
      end else begin
         zc = cordic_ff[STAGES].z;
      end
      zr = $unsigned(zc) + Z_W'(Z_HALF);
      if (cordic_ff[STAGES].quad.y_zero) begin
         t_in = '0;
      end else if (cordic_ff[STAGES].quad.x_zero) begin
         t_in = H90;
      end else begin
         t_in = HEAD_WIDTH'(zr >> Z_SHIFT);
      end
   end

   // quadrant fold
   always_comb begin
      if (quad_t_ff.x_zero && quad_t_ff.y_zero) begin
         heading_in = '0;
      end else begin
         case ({quad_t_ff.y_neg, quad_t_ff.x_neg})
            2'b00:   heading_in = t_ff;
            2'b01:   heading_in = H180 - t_ff;
            2'b11:   heading_in = H180 + t_ff;
            2'b10:   heading_in = (t_ff == '0) ? '0 : H360 - t_ff;
            default: heading_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= req_bus.valid;
         for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= STAGES; k++) begin
         if (adv[k]) cordic_ff[k] <= cordic_in[k];
      end
      if (adv[ROUND_STG]) begin
         t_ff      <= t_in;
         quad_t_ff <= cordic_ff[STAGES].quad;
      end
      if (adv[OUT_STG]) heading_ff <= heading_in;
   end

endmodule

`default_nettype wire

// File: rtl/vad_checker.sv
`default_nettype none

module vad_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire vad_pkg::heading_type rsp_heading
);
   import vad_pkg::*;

   // heading stays below a full turn
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading < H360))
      else $error("heading out of range");

   // a stalled beat stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_heading))
      else $error("rsp heading changed while stalled");

   // empty output stage means the whole pipe can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with empty output stage");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind vector_angle_degrees vad_checker u_vad_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_heading (rsp_bus.heading)
);

`default_nettype wire
